/* src/bapq_pkg.sv */
`timescale 1ns / 1ps

package bapq_pkg;

  localparam int PALETTE_SIZE      = 16;
  localparam int MAX_WINDOW_PIXELS = 256;

  localparam int PIX_W            = 16;
  localparam int CH_W             = 5;
  localparam int CH_MAX           = 31;
  localparam int IDX_W            = 4;
  localparam int DIST_W           = 15;
  localparam int SQ_W             = 2 * CH_W;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int PAL_WORDS        = 4;
  localparam int ENTRIES_PER_WORD = CFG_W / PIX_W;

  localparam int CNT_W  = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SUM_W  = $clog2(CH_MAX * MAX_WINDOW_PIXELS + 1);
  localparam int DIV_W  = (SUM_W > CNT_W + CH_W - 1) ? SUM_W : CNT_W + CH_W - 1;
  localparam int STEP_W = $clog2(CH_W);

  localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(32767);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             direct;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] palette_index;
    logic [PIX_W-1:0] average_color;
  } out_word_t;

  typedef struct packed {
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic              vld;
    rgb_t              col;
    logic [IDX_W-1:0]  best;
    logic [DIST_W-1:0] score;
  } cell_bus_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_SEARCH
  } state_t;

  function automatic rgb_t pix_rgb(input logic [PIX_W-1:0] p);
    return rgb_t'(p[PIX_W-1:1]);
  endfunction

endpackage

/* src/bapq_cell.sv */
`timescale 1ns / 1ps

module bapq_cell
  import bapq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [PIX_W-1:0] entry,
  input  cell_bus_t        up,
  output cell_bus_t        down
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  rgb_t              pal;
  logic [DIST_W-1:0] cand;
  logic              vld_r;
  rgb_t              col_r;
  logic [IDX_W-1:0]  best_r;
  logic [IDX_W-1:0]  best_nxt;
  logic [DIST_W-1:0] score_r;
  logic [DIST_W-1:0] score_nxt;

  always_comb begin
    pal  = pix_rgb(entry);
    cand = DIST_W'(sq_diff(up.col.b, pal.b)) + DIST_W'(sq_diff(up.col.r, pal.r))
         + DIST_W'(sq_diff(up.col.g, pal.g));
    best_nxt  = up.best;
    score_nxt = up.score;
    if (cand < up.score) begin
      best_nxt  = cell_idx;
      score_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= up.col;
    best_r  <= best_nxt;
    score_r <= score_nxt;
  end

  assign down.vld   = vld_r;
  assign down.col   = col_r;
  assign down.best  = best_r;
  assign down.score = score_r;

endmodule

/* src/bapq_div.sv */
`timescale 1ns / 1ps

module bapq_div
  import bapq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic [SUM_W-1:0] sum_b,
  input  logic [SUM_W-1:0] sum_r,
  input  logic [SUM_W-1:0] sum_g,
  output logic             done,
  output rgb_t             quot
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  rem_r   [3];
  logic [DIV_W-1:0]  rem_nxt [3];
  logic [CH_W-1:0]   q_r     [3];
  logic [CH_W-1:0]   q_nxt   [3];
  logic [DIV_W-1:0]  trial;

  always_comb begin
    trial = DIV_W'(cnt_r) << step_r;
    for (int c = 0; c < 3; c++) begin
      rem_nxt[c] = rem_r[c];
      q_nxt[c]   = q_r[c];
      if (rem_r[c] >= trial) begin
        rem_nxt[c]       = rem_r[c] - trial;
        q_nxt[c][step_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r   <= STEP_W'(CH_W - 1);
      cnt_r    <= count;
      rem_r[0] <= DIV_W'(sum_b);
      rem_r[1] <= DIV_W'(sum_r);
      rem_r[2] <= DIV_W'(sum_g);
      for (int c = 0; c < 3; c++) begin
        q_r[c] <= '0;
      end
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= rem_nxt[c];
        q_r[c]   <= q_nxt[c];
      end
    end
  end

  assign done   = done_r;
  assign quot.b = q_r[0];
  assign quot.r = q_r[1];
  assign quot.g = q_r[2];

endmodule

/* src/box_average_palette_quantizer_top.sv */
`timescale 1ns / 1ps

// Averages the pixels of a downscaling window and maps the average to the
// nearest of sixteen palette colours held in four 64-bit registers.
// Source words arrive on the in_ channel, one pixel each; results leave on
// the out_ channel, one word per window or per direct pixel.
// Pixels that are neither last nor direct are added to the window sums.
// After a last word the average is formed in the iterative divider, then
// searched in the chain of comparison cells once the output register is
// free; a direct word skips the divider. The input is stalled while a
// window end or direct word is processed, so the next word is accepted
// only after its search has finished. A finished result waits in the
// output register while new pixels of the next window are accepted; the
// next search is held back until it is taken. Palette registers must be
// written through the cfg_ port only while the block is idle, which the
// block does not enforce. Reset clears palette, window sums, pending result.

module box_average_palette_quantizer_top
  import bapq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t            state_r;
  state_t            state_nxt;
  logic [CFG_W-1:0]  palette_r [PAL_WORDS];
  logic [SUM_W-1:0]  sum_b_r;
  logic [SUM_W-1:0]  sum_r_r;
  logic [SUM_W-1:0]  sum_g_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_b_nxt;
  logic [SUM_W-1:0]  sum_r_nxt;
  logic [SUM_W-1:0]  sum_g_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  rgb_t              px;
  logic              in_acc;
  logic              div_start;
  logic              div_done;
  rgb_t              div_quot;
  logic              launch;
  rgb_t              srch_col_r;
  logic [PIX_W-1:0]  key_r;
  logic              out_vld_r;
  out_word_t         out_word_r;
  cell_bus_t         chain [PALETTE_SIZE+1];

  assign px     = pix_rgb(in_word.pixel);
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    sum_b_nxt = sum_b_r;
    sum_r_nxt = sum_r_r;
    sum_g_nxt = sum_g_r;
    cnt_nxt   = cnt_r;
    if (cnt_r < CNT_W'(MAX_WINDOW_PIXELS)) begin
      sum_b_nxt = sum_b_r + SUM_W'(px.b);
      sum_r_nxt = sum_r_r + SUM_W'(px.r);
      sum_g_nxt = sum_g_r + SUM_W'(px.g);
      cnt_nxt   = cnt_r + CNT_W'(1);
    end
  end

  assign div_start = in_acc && !in_word.direct && in_word.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_word.direct) begin
          state_nxt = ST_WAIT;
        end else if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_vld_r) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[PALETTE_SIZE].vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    launch   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_DIV:    in_stall = 1'b1;
      ST_WAIT:   launch   = !out_vld_r;
      ST_SEARCH: in_stall = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sum_b_r   <= '0;
      sum_r_r   <= '0;
      sum_g_r   <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      for (int w = 0; w < PAL_WORDS; w++) begin
        palette_r[w] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        palette_r[cfg_index] <= cfg_data;
      end
      if (in_acc) begin
        if (in_word.direct || in_word.last) begin
          sum_b_r <= '0;
          sum_r_r <= '0;
          sum_g_r <= '0;
          cnt_r   <= '0;
        end else begin
          sum_b_r <= sum_b_nxt;
          sum_r_r <= sum_r_nxt;
          sum_g_r <= sum_g_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
      if (chain[PALETTE_SIZE].vld) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.direct) begin
      srch_col_r <= px;
      key_r      <= in_word.pixel;
    end else if ((state_r == ST_DIV) && div_done) begin
      srch_col_r <= div_quot;
      key_r      <= {div_quot, 1'b0};
    end
    if (chain[PALETTE_SIZE].vld) begin
      out_word_r.palette_index <= (key_r <= PIX_W'(1)) ? '0 : chain[PALETTE_SIZE].best;
      out_word_r.average_color <= key_r;
    end
  end

  bapq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (cnt_nxt),
    .sum_b (sum_b_nxt),
    .sum_r (sum_r_nxt),
    .sum_g (sum_g_nxt),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign chain[0].vld   = launch;
  assign chain[0].col   = srch_col_r;
  assign chain[0].best  = '0;
  assign chain[0].score = DIST_INIT;

  for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
    bapq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .entry    (palette_r[k / ENTRIES_PER_WORD][PIX_W * (k % ENTRIES_PER_WORD) +: PIX_W]),
      .up       (chain[k]),
      .down     (chain[k+1])
    );
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule
